// ===== rtl/core/lfu_pkg.sv =====
// Shared types and constants for the LFU cache lookup and update unit.
package lfu_pkg;

	localparam int CFG_W = 5;

	typedef logic [31:0] key_t;
	typedef logic [31:0] data_t;
	typedef logic [31:0] count_t;
	typedef logic [CFG_W-1:0] cfg_t;

	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_PUT = 1'b1;

	localparam cfg_t   CFG_RESET = cfg_t'(16);
	localparam count_t COUNT_ONE = count_t'(1);
	localparam count_t COUNT_MAX = '1;

	// Write enables towards the entry store.
	typedef struct packed {
		logic key_we;
		logic data_we;
		logic count_we;
		logic rank_we;
		logic set_valid;
	} store_ctl_t;

	// Flags from the shared compare unit.
	typedef struct packed {
		logic key_eq;
		logic count_lt;
		logic count_eq;
		logic rank_gt;
		logic bump;
	} cmp_t;

endpackage

// ===== rtl/core/lfu_if.sv =====
// Request and response channel interfaces of the LFU cache unit.
interface lfu_req_if import lfu_pkg::*; ();
	logic  valid;
	logic  ready;
	logic  command;
	key_t  key;
	data_t value_in;

	modport source(output valid, command, key, value_in, input ready);
	modport sink(input valid, command, key, value_in, output ready);
endinterface

interface lfu_rsp_if import lfu_pkg::*; ();
	logic  valid;
	logic  ready;
	logic  hit;
	data_t value_out;
	logic  evicted;
	key_t  evicted_key;

	modport source(output valid, hit, value_out, evicted, evicted_key, input ready);
	modport sink(input valid, hit, value_out, evicted, evicted_key, output ready);
endinterface

// ===== rtl/core/lfu_store.sv =====
// Entry store: valid flops plus key, data, count and rank memories.
module lfu_store import lfu_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int IDX_W = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  store_ctl_t       ctl,
	input  logic [IDX_W-1:0] rd_idx,
	input  logic [IDX_W-1:0] wr_idx,
	input  key_t             wr_key,
	input  data_t            wr_data,
	input  count_t           wr_count,
	input  logic [IDX_W-1:0] wr_rank,
	output logic             rd_valid,
	output key_t             rd_key,
	output data_t            rd_data,
	output count_t           rd_count,
	output logic [IDX_W-1:0] rd_rank
);

	logic [DEPTH-1:0] valid_q;
	key_t             key_mem   [DEPTH];
	data_t            data_mem  [DEPTH];
	count_t           count_mem [DEPTH];
	logic [IDX_W-1:0] rank_mem  [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_valid <= 1'b0;
		end else begin
			if (ctl.set_valid)
				valid_q[wr_idx] <= 1'b1;
			rd_valid <= valid_q[rd_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.key_we)
			key_mem[wr_idx] <= wr_key;
		if (ctl.data_we)
			data_mem[wr_idx] <= wr_data;
		if (ctl.count_we)
			count_mem[wr_idx] <= wr_count;
		if (ctl.rank_we)
			rank_mem[wr_idx] <= wr_rank;
		rd_key   <= key_mem[rd_idx];
		rd_data  <= data_mem[rd_idx];
		rd_count <= count_mem[rd_idx];
		rd_rank  <= rank_mem[rd_idx];
	end

endmodule

// ===== rtl/core/lfu_cmp.sv =====
// Shared compare and increment unit used by both passes over the store.
module lfu_cmp import lfu_pkg::*; #(
	parameter int RANK_W = 4
) (
	input  key_t              key_a,
	input  key_t              key_b,
	input  count_t            count_a,
	input  count_t            count_b,
	input  logic [RANK_W-1:0] rank_a,
	input  logic [RANK_W-1:0] rank_b,
	input  logic              all_inc,
	output cmp_t              flags,
	output logic [RANK_W-1:0] rank_inc,
	output count_t            count_inc
);

	always_comb begin
		flags.key_eq   = (key_a == key_b);
		flags.count_lt = (count_a < count_b);
		flags.count_eq = (count_a == count_b);
		flags.rank_gt  = (rank_a > rank_b);
		// age every entry newer than the reference, or all of them on a plain insert
		flags.bump     = all_inc || (rank_a < rank_b);
		rank_inc       = rank_a + RANK_W'(1);
		count_inc      = (count_b == COUNT_MAX) ? COUNT_MAX : count_b + COUNT_ONE;
	end

endmodule

// ===== rtl/core/lfu_cache_lookup_update_unit.sv =====
// A request walks the entry memories through the read port in a scan pass, then a decide
// step, then a rank pass that a get miss skips, and then waits in the done state until
// the response register is free. One request is in flight at a time, set by the single
// read port of the entry memories, walked once to scan and once to re-rank.
// Reset clears valid bits, occupancy, sequencer and response; capacity returns to 16.
// The entry memories are not cleared: an invalid entry is never used.
module lfu_cache_lookup_update_unit import lfu_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  cfg_t        cfg_wdata,
	lfu_req_if.sink     req,
	lfu_rsp_if.source   rsp
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int OCC_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (OCC_W > CFG_W) ? OCC_W : CFG_W;
	localparam logic [IDX_W-1:0] LAST = IDX_W'(CAPACITY - 1);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_SCAN   = 5'b00010,
		S_DECIDE = 5'b00100,
		S_RANK   = 5'b01000,
		S_DONE   = 5'b10000
	} state_t;

	state_t           state_q;
	cfg_t             cap_q;
	logic [OCC_W-1:0] occ_q;
	logic             issue_q;
	logic [IDX_W-1:0] ra_q;
	logic             val_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             found_q, free_q, have_v_q, all_inc_q, rsp_valid_q;

	logic             cmd_q;
	key_t             key_q;
	data_t            val_q;
	logic [IDX_W-1:0] tgt_q, free_idx_q, v_idx_q;
	logic [IDX_W-1:0] tgt_rank_q, v_rank_q;
	count_t           tgt_count_q, v_count_q;
	data_t            get_data_q;
	key_t             v_key_q;
	logic             res_hit_q, res_ev_q;
	data_t            res_vout_q;
	key_t             res_evkey_q;
	logic             out_hit_q, out_ev_q;
	data_t            out_vout_q;
	key_t             out_evkey_q;

	store_ctl_t       ctl;
	logic [IDX_W-1:0] wr_idx, wr_rank;
	count_t           wr_count;
	logic             rd_valid;
	key_t             rd_key;
	data_t            rd_data;
	count_t           rd_count;
	logic [IDX_W-1:0] rd_rank;

	cmp_t             flags;
	logic [IDX_W-1:0] rank_inc, rank_ref;
	count_t           count_inc, count_ref;

	logic [CMP_W-1:0] cap_ext, cap_eff;
	logic             scan_end, better, ins, evict, load_rsp;
	logic [IDX_W-1:0] tgt_d;

	lfu_store #(
		.DEPTH (CAPACITY),
		.IDX_W (IDX_W)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.rd_idx   (ra_q),
		.wr_idx   (wr_idx),
		.wr_key   (key_q),
		.wr_data  (val_q),
		.wr_count (wr_count),
		.wr_rank  (wr_rank),
		.rd_valid (rd_valid),
		.rd_key   (rd_key),
		.rd_data  (rd_data),
		.rd_count (rd_count),
		.rd_rank  (rd_rank)
	);

	assign rank_ref  = (state_q == S_RANK) ? tgt_rank_q : v_rank_q;
	assign count_ref = (state_q == S_DECIDE) ? tgt_count_q : v_count_q;

	lfu_cmp #(
		.RANK_W (IDX_W)
	) u_cmp (
		.key_a     (rd_key),
		.key_b     (key_q),
		.count_a   (rd_count),
		.count_b   (count_ref),
		.rank_a    (rd_rank),
		.rank_b    (rank_ref),
		.all_inc   (all_inc_q),
		.flags     (flags),
		.rank_inc  (rank_inc),
		.count_inc (count_inc)
	);

	always_comb begin
		cap_ext = CMP_W'(cap_q);
		if (cap_q == '0)
			cap_eff = CMP_W'(1);
		else if (cap_ext > CMP_W'(CAPACITY))
			cap_eff = CMP_W'(CAPACITY);
		else
			cap_eff = cap_ext;
	end

	assign scan_end = val_s1 && (idx_s1 == LAST);
	assign better   = !have_v_q || flags.count_lt || (flags.count_eq && flags.rank_gt);
	assign ins      = !found_q && (cmd_q == CMD_PUT);
	assign evict    = ins && ((CMP_W'(occ_q) >= cap_eff) || !free_q);
	assign tgt_d    = found_q ? tgt_q : (evict ? v_idx_q : free_idx_q);
	assign load_rsp = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);

	// Target entry is written during the decide cycle; the rank pass then skips it.
	always_comb begin
		ctl      = '0;
		wr_idx   = idx_s1;
		wr_rank  = rank_inc;
		wr_count = found_q ? count_inc : COUNT_ONE;
		case (state_q)
			S_DECIDE: begin
				wr_idx        = tgt_d;
				wr_rank       = '0;
				ctl.key_we    = ins;
				ctl.data_we   = found_q ? (cmd_q == CMD_PUT) : ins;
				ctl.count_we  = found_q || ins;
				ctl.rank_we   = found_q || ins;
				ctl.set_valid = ins;
			end
			S_RANK: begin
				ctl.rank_we = val_s1 && rd_valid && (idx_s1 != tgt_q) && flags.bump;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cap_q       <= CFG_RESET;
			occ_q       <= '0;
			issue_q     <= 1'b0;
			ra_q        <= '0;
			val_s1      <= 1'b0;
			idx_s1      <= '0;
			found_q     <= 1'b0;
			free_q      <= 1'b0;
			have_v_q    <= 1'b0;
			all_inc_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				cap_q <= cfg_wdata;

			// walk the read port one entry a cycle
			if (issue_q) begin
				val_s1 <= 1'b1;
				idx_s1 <= ra_q;
				if (ra_q == LAST)
					issue_q <= 1'b0;
				else
					ra_q <= ra_q + IDX_W'(1);
			end else begin
				val_s1 <= 1'b0;
			end

			if (load_rsp)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						state_q  <= S_SCAN;
						issue_q  <= 1'b1;
						ra_q     <= '0;
						found_q  <= 1'b0;
						free_q   <= 1'b0;
						have_v_q <= 1'b0;
					end
				end
				S_SCAN: begin
					if (val_s1) begin
						if (rd_valid && flags.key_eq)
							found_q <= 1'b1;
						if (!rd_valid)
							free_q <= 1'b1;
						if (rd_valid && better)
							have_v_q <= 1'b1;
					end
					if (scan_end)
						state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					all_inc_q <= ins && !evict;
					if (ins && !evict)
						occ_q <= occ_q + OCC_W'(1);
					if (found_q || ins) begin
						state_q <= S_RANK;
						issue_q <= 1'b1;
						ra_q    <= '0;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_RANK: begin
					if (scan_end)
						state_q <= S_DONE;
				end
				S_DONE: begin
					if (load_rsp)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && req.valid) begin
			cmd_q <= req.command;
			key_q <= req.key;
			val_q <= req.value_in;
		end
		if ((state_q == S_SCAN) && val_s1) begin
			// first matching entry only
			if (rd_valid && flags.key_eq && !found_q) begin
				tgt_q       <= idx_s1;
				tgt_rank_q  <= rd_rank;
				tgt_count_q <= rd_count;
				get_data_q  <= rd_data;
			end
			if (!rd_valid && !free_q)
				free_idx_q <= idx_s1;
			if (rd_valid && better) begin
				v_idx_q   <= idx_s1;
				v_rank_q  <= rd_rank;
				v_count_q <= rd_count;
				v_key_q   <= rd_key;
			end
		end
		if (state_q == S_DECIDE) begin
			tgt_q <= tgt_d;
			if (!found_q)
				tgt_rank_q <= v_rank_q;
			res_hit_q   <= found_q;
			res_vout_q  <= (found_q && (cmd_q == CMD_GET)) ? get_data_q : '0;
			res_ev_q    <= evict;
			res_evkey_q <= evict ? v_key_q : '0;
		end
		if (load_rsp) begin
			out_hit_q   <= res_hit_q;
			out_vout_q  <= res_vout_q;
			out_ev_q    <= res_ev_q;
			out_evkey_q <= res_evkey_q;
		end
	end

	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = rsp_valid_q;
	assign rsp.hit         = out_hit_q;
	assign rsp.value_out   = out_vout_q;
	assign rsp.evicted     = out_ev_q;
	assign rsp.evicted_key = out_evkey_q;

endmodule

// ===== rtl/core/lfu_chk.sv =====
// Port-level checks on the LFU cache unit, bound to its top level.
module lfu_chk import lfu_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	input logic  req_valid,
	input logic  req_ready,
	input logic  rsp_valid,
	input logic  rsp_ready,
	input logic  rsp_hit,
	input data_t rsp_value_out,
	input logic  rsp_evicted,
	input key_t  rsp_evicted_key
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response beat dropped while stalled");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous one still in flight");

	a_evict_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_evicted |-> !rsp_hit)
		else $error("eviction reported on a hit");

	a_evkey_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_evicted |-> rsp_evicted_key == '0)
		else $error("evicted key set without eviction");

	a_value_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_value_out != '0) |-> rsp_hit && !rsp_evicted)
		else $error("value returned without a hit");

endmodule

bind lfu_cache_lookup_update_unit lfu_chk u_lfu_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_hit         (rsp.hit),
	.rsp_value_out   (rsp.value_out),
	.rsp_evicted     (rsp.evicted),
	.rsp_evicted_key (rsp.evicted_key)
);
